>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the rtl; define NO_ASSERTIONS to drop them
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, clk, rst, a, b)
`define ASSERT_NXT(lbl, clk, rst, a, b)

`endif

`endif

>>> rtl/core/dscw_pkg.sv
// ----------------------------------------------------------------------------
// dscw_pkg
// types, drive state codes, command codes and control word bits
// ----------------------------------------------------------------------------
package dscw_pkg;

  typedef struct packed {
    logic [15:0] status_word;
    logic [15:0] control_in;
    logic [2:0]  goal_state;
    logic [2:0]  preferred_path;
  } dscw_req_t;

  typedef struct packed {
    logic [15:0] control_out;
    logic [2:0]  drive_state;
  } dscw_res_t;

  // drive states
  localparam logic [2:0] ST_NOT_READY      = 3'd0;
  localparam logic [2:0] ST_SOD            = 3'd1;
  localparam logic [2:0] ST_READY          = 3'd2;
  localparam logic [2:0] ST_SWITCHED_ON    = 3'd3;
  localparam logic [2:0] ST_OP_ENABLED     = 3'd4;
  localparam logic [2:0] ST_QUICK_STOP     = 3'd5;
  localparam logic [2:0] ST_FAULT_REACTION = 3'd6;
  localparam logic [2:0] ST_FAULT          = 3'd7;

  // commands
  localparam logic [2:0] CMD_NONE         = 3'd0;
  localparam logic [2:0] CMD_SHUTDOWN     = 3'd1;
  localparam logic [2:0] CMD_SWITCH_ON    = 3'd2;
  localparam logic [2:0] CMD_DISABLE_VOLT = 3'd3;
  localparam logic [2:0] CMD_QUICK_STOP   = 3'd4;
  localparam logic [2:0] CMD_DISABLE_OP   = 3'd5;
  localparam logic [2:0] CMD_ENABLE_OP    = 3'd6;
  localparam logic [2:0] CMD_FAULT_RESET  = 3'd7;

  // status word masks and patterns
  localparam logic [15:0] SW_MASK_A       = 16'h004f;
  localparam logic [15:0] SW_MASK_B       = 16'h006f;
  localparam logic [15:0] SW_NOT_READY    = 16'h0000;
  localparam logic [15:0] SW_SOD          = 16'h0040;
  localparam logic [15:0] SW_FAULT_REACT  = 16'h000f;
  localparam logic [15:0] SW_FAULT        = 16'h0008;
  localparam logic [15:0] SW_READY        = 16'h0021;
  localparam logic [15:0] SW_SWITCHED_ON  = 16'h0023;
  localparam logic [15:0] SW_OP_ENABLED   = 16'h0027;
  localparam logic [15:0] SW_QUICK_STOP   = 16'h0007;

  // control word bits
  localparam logic [15:0] CW_ENABLE_OP      = 16'h0008;
  localparam logic [15:0] CW_QUICK_STOP     = 16'h0004;
  localparam logic [15:0] CW_ENABLE_VOLTAGE = 16'h0002;
  localparam logic [15:0] CW_SWITCH_ON      = 16'h0001;
  localparam logic [15:0] CW_FAULT_RESET    = 16'h0080;

endpackage

>>> rtl/core/dscw_decode.sv
// ----------------------------------------------------------------------------
// dscw_decode
// status word to drive state decode
// ----------------------------------------------------------------------------
module dscw_decode (
  input  logic [15:0] status_word,
  output logic [2:0]  drive_state
);
  import dscw_pkg::*;

  always_comb begin
    drive_state = ST_NOT_READY;
    case (status_word & SW_MASK_A)
      SW_NOT_READY:   drive_state = ST_NOT_READY;
      SW_SOD:         drive_state = ST_SOD;
      SW_FAULT_REACT: drive_state = ST_FAULT_REACTION;
      SW_FAULT:       drive_state = ST_FAULT;
      default: begin
        case (status_word & SW_MASK_B)
          SW_READY:       drive_state = ST_READY;
          SW_SWITCHED_ON: drive_state = ST_SWITCHED_ON;
          SW_OP_ENABLED:  drive_state = ST_OP_ENABLED;
          SW_QUICK_STOP:  drive_state = ST_QUICK_STOP;
          default:        drive_state = ST_NOT_READY;
        endcase
      end
    endcase
  end

endmodule

>>> rtl/core/dscw_cmd_sel.sv
// ----------------------------------------------------------------------------
// dscw_cmd_sel
// picks the next command from drive state, target and preferred path
// ----------------------------------------------------------------------------
module dscw_cmd_sel (
  input  logic [2:0] drive_state,
  input  logic [2:0] goal_state,
  input  logic [2:0] preferred_path,
  output logic [2:0] cmd
);
  import dscw_pkg::*;

  logic [2:0] tgt;
  logic       main_st;

  always_comb begin
    // target outside the main states is clamped
    if (goal_state == ST_NOT_READY) begin
      tgt = ST_SOD;
    end else if (goal_state inside {[ST_QUICK_STOP:ST_FAULT]}) begin
      tgt = ST_OP_ENABLED;
    end else begin
      tgt = goal_state;
    end
  end

  assign main_st = (drive_state inside {[ST_SOD:ST_OP_ENABLED]});

  always_comb begin
    cmd = CMD_NONE;
    if (drive_state == ST_FAULT) begin
      cmd = CMD_FAULT_RESET;
    end else if (main_st && drive_state < tgt) begin
      case (drive_state)
        ST_SOD:         cmd = CMD_SHUTDOWN;
        ST_READY:       cmd = CMD_SWITCH_ON;
        ST_SWITCHED_ON: cmd = CMD_ENABLE_OP;
        default:        cmd = CMD_NONE;
      endcase
    end else if (main_st && drive_state > tgt) begin
      if (preferred_path == CMD_DISABLE_VOLT) begin
        cmd = CMD_DISABLE_VOLT;
      end else begin
        case (drive_state)
          ST_OP_ENABLED: begin
            if (preferred_path == CMD_SHUTDOWN) begin
              cmd = CMD_SHUTDOWN;
            end else if (preferred_path == CMD_DISABLE_OP) begin
              cmd = CMD_DISABLE_OP;
            end else begin
              cmd = CMD_QUICK_STOP;
            end
          end
          ST_SWITCHED_ON: cmd = CMD_SHUTDOWN;
          ST_READY:       cmd = CMD_DISABLE_VOLT;
          default:        cmd = CMD_NONE;
        endcase
      end
    end
  end

endmodule

>>> rtl/core/dscw_apply.sv
// ----------------------------------------------------------------------------
// dscw_apply
// applies a command to the control word, other bits pass through
// ----------------------------------------------------------------------------
module dscw_apply (
  input  logic [2:0]  cmd,
  input  logic [15:0] control_in,
  output logic [15:0] control_out
);
  import dscw_pkg::*;

  always_comb begin
    case (cmd)
      CMD_SHUTDOWN:
        control_out = (control_in & ~(CW_FAULT_RESET | CW_SWITCH_ON))
                      | CW_QUICK_STOP | CW_ENABLE_VOLTAGE;
      CMD_SWITCH_ON, CMD_DISABLE_OP:
        control_out = (control_in & ~(CW_FAULT_RESET | CW_ENABLE_OP))
                      | CW_QUICK_STOP | CW_ENABLE_VOLTAGE | CW_SWITCH_ON;
      CMD_DISABLE_VOLT:
        control_out = control_in & ~(CW_FAULT_RESET | CW_ENABLE_VOLTAGE);
      CMD_QUICK_STOP:
        control_out = (control_in & ~(CW_FAULT_RESET | CW_QUICK_STOP))
                      | CW_ENABLE_VOLTAGE;
      CMD_ENABLE_OP:
        control_out = (control_in & ~CW_FAULT_RESET)
                      | CW_ENABLE_OP | CW_QUICK_STOP | CW_ENABLE_VOLTAGE | CW_SWITCH_ON;
      CMD_FAULT_RESET:
        control_out = control_in | CW_FAULT_RESET;
      default:
        control_out = control_in;
    endcase
  end

endmodule

>>> rtl/core/drive_state_controlword_step.sv
// ----------------------------------------------------------------------------
// drive_state_controlword_step
// Drive state machine control word step. Each request carries a drive status
// word, the last control word, a target state and a preferred downward path;
// the result is the decoded drive state and the next control word. A request
// is captured in an input register, decoded and updated in one combinational
// pass, and stored in a result register, so the result is presented from the
// result register after passing through the input register, and one request
// is taken every cycle while results are taken. While a finished result waits,
// a new request is accepted only if the input register is empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module drive_state_controlword_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  dscw_pkg::dscw_req_t req,
  output logic               res_valid,
  input  logic               res_ready,
  output dscw_pkg::dscw_res_t res
);
  import dscw_pkg::*;

  dscw_req_t   s1;
  logic        s1_valid;
  logic        s2_take;
  logic [2:0]  state;
  logic [2:0]  cmd;
  logic [15:0] cw;

  assign s2_take   = !res_valid || res_ready;
  assign req_ready = !s1_valid || s2_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1 <= req;
    end
  end

  dscw_decode u_decode (
    .status_word (s1.status_word),
    .drive_state (state)
  );

  dscw_cmd_sel u_cmd_sel (
    .drive_state    (state),
    .goal_state     (s1.goal_state),
    .preferred_path (s1.preferred_path),
    .cmd            (cmd)
  );

  dscw_apply u_apply (
    .cmd         (cmd),
    .control_in  (s1.control_in),
    .control_out (cw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s2_take) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take && s1_valid) begin
      res.control_out <= cw;
      res.drive_state <= state;
    end
  end

  `ASSERT_NXT(a_s2_load, clk, rst, s1_valid && s2_take, res_valid)
  `ASSERT_IMP(a_stall_full, clk, rst, !req_ready, s1_valid && res_valid)
  `ASSERT_IMP(a_fault_rst, clk, rst, res_valid && res.drive_state == ST_FAULT, res.control_out[7])

endmodule
